// ----- hw/rtl/box_blur_3x3_edge_average_assert.svh -----
// Assertion macros for the 3x3 box blur checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_ASSERT_SVH
// Same-cycle implication, off during reset.
`define BB3_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, off during reset.
`define BB3_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Next-cycle implication, checked during reset too.
`define BB3_AST_NXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/bb3_pkg.sv -----
// Shared constants, types and the reciprocal table for the 3x3 box blur.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CFG_W     = 12;
  localparam int EW_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int IN_ROW_W  = CFG_W + 1;
  localparam int OUT_ROW_W = CFG_W;
  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int SUM_W     = 12;
  localparam int CNT_W     = 4;
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_K     = 18;
  localparam int RECIP_W   = 18;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [8:0][PIX_W-1:0] bb3_win_t;

  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } bb3_mask_t;

  // ceil(2^DIV_K / (2*count)); exact for numerators below 2^NUM_W.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd1:    m = RECIP_W'(131072);
      4'd2:    m = RECIP_W'(65536);
      4'd3:    m = RECIP_W'(43691);
      4'd4:    m = RECIP_W'(32768);
      4'd5:    m = RECIP_W'(26215);
      4'd6:    m = RECIP_W'(21846);
      4'd7:    m = RECIP_W'(18725);
      4'd8:    m = RECIP_W'(16384);
      4'd9:    m = RECIP_W'(14564);
      default: m = '0;
    endcase
    return m;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bb3_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bb3_avg.sv -----
// Masked 3x3 sum and rounded average per channel.
// Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bb3_avg (
  input  wire logic                    clk,
  input  wire logic                    start,
  input  wire bb3_pkg::bb3_win_t       win,
  input  wire bb3_pkg::bb3_mask_t      mask,
  output logic [bb3_pkg::PIX_W-1:0]    avg
);
  logic [2:0][bb3_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [bb3_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [bb3_pkg::RECIP_W-1:0]    m;

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (mask.row_ok[r] && mask.col_ok[c]) begin
          cnt_nxt = cnt_nxt + 1'b1;
          for (int ch = 0; ch < 3; ch++) begin
            sum_nxt[ch] = sum_nxt[ch] +
              bb3_pkg::SUM_W'(win[r*3+c][ch*bb3_pkg::CH_W +: bb3_pkg::CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // floor((2*sum + count) / (2*count)) by reciprocal multiply
  always_comb begin
    logic [bb3_pkg::NUM_W-1:0]                   num;
    logic [bb3_pkg::NUM_W+bb3_pkg::RECIP_W-1:0] prod;
    m = bb3_pkg::recip(cnt_r);
    for (int ch = 0; ch < 3; ch++) begin
      num  = {sum_r[ch], 1'b0} + bb3_pkg::NUM_W'(cnt_r);
      prod = (bb3_pkg::NUM_W+bb3_pkg::RECIP_W)'(num) *
             (bb3_pkg::NUM_W+bb3_pkg::RECIP_W)'(m);
      avg[ch*bb3_pkg::CH_W +: bb3_pkg::CH_W] =
        prod[bb3_pkg::DIV_K +: bb3_pkg::CH_W];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/box_blur_3x3_edge_average.sv -----
// Top level of the 3x3 box blur: control sequencer, window and counters.
// Depends on bb3_pkg, bb3_ram and bb3_avg.
`timescale 1ns / 1ps
`default_nettype none
// 3x3 box blur over an RGB raster stream. Each output channel is the average
// of the in-frame neighbors (4 at corners, 6 on edges, 9 inside), rounded
// half up. The output for pixel k leaves when pixel k+width+1 arrives; after
// the frame, drain ticks (tuser = 1) or extra pixels release the remaining
// outputs, and the final one carries tuser = 1. A drain tick while pixels
// are still expected is absorbed with no output. Two line stores sit in
// single-port-read RAMs with a registered read; input is taken only in
// S_IDLE, and each item reads its column, then writes it back in S_ADV,
// returning to S_IDLE if it made no output, else passing S_SUM and S_DIV
// (waiting there on out_tready). A drain in a one-row frame that first
// steps without output rereads in S_RD and steps again. Configuration is
// taken at once and applies immediately.
module box_blur_3x3_edge_average (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: in_red[7:0], in_green[15:8], in_blue[23:16]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // in_tuser: cmd
  input  wire logic        in_tuser,
  // out_tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  // out_tuser: frame_last
  output logic             out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_ADV, S_RD, S_SUM, S_DIV} state_t;

  localparam int COL_W = bb3_pkg::COL_W;
  localparam int EW_W  = bb3_pkg::EW_W;

  state_t state_r, state_nxt;
  logic [bb3_pkg::CFG_W-1:0]     fw_r, fh_r;
  logic [COL_W-1:0]              in_col_r, in_col_nxt;
  logic [bb3_pkg::IN_ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]              out_col_r, out_col_nxt;
  logic [bb3_pkg::OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [bb3_pkg::PIX_W-1:0]     pix_r, pix_nxt;
  logic                          cmpl_r, cmpl_nxt, retry_r, retry_nxt;
  logic                          last_r, last_nxt;
  bb3_pkg::bb3_win_t             win_r, win_nxt;
  bb3_pkg::bb3_mask_t            mask;
  logic                          ovld_r, ovld_nxt, olast_r, olast_nxt;
  logic [bb3_pkg::PIX_W-1:0]     odata_r, odata_nxt;

  logic [EW_W-1:0]              eff_w, col_inc, ocol_inc;
  logic [bb3_pkg::CFG_W-1:0]    eff_h;
  logic [bb3_pkg::IN_ROW_W-1:0] orow_inc;
  logic                         complete, emit, accept, rd_en, wr_en;
  logic [bb3_pkg::PIX_W-1:0]    up_rd, mid_rd, avg;

  assign cfg_ready = 1'b1;

  // Effective frame size: zero acts as one, width clamps at the store depth.
  always_comb begin
    if (fw_r == '0) begin
      eff_w = EW_W'(1);
    end else if (EW_W'(fw_r) > EW_W'(bb3_pkg::MAX_WIDTH)) begin
      eff_w = EW_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      eff_w = EW_W'(fw_r);
    end
    eff_h    = (fh_r == '0) ? bb3_pkg::CFG_W'(1) : fh_r;
    col_inc  = EW_W'(in_col_r) + EW_W'(1);
    ocol_inc = EW_W'(out_col_r) + EW_W'(1);
    orow_inc = bb3_pkg::IN_ROW_W'(out_row_r) + bb3_pkg::IN_ROW_W'(1);
  end

  assign complete = in_row_r >= bb3_pkg::IN_ROW_W'(eff_h);
  assign emit = (in_row_r >= bb3_pkg::IN_ROW_W'(2)) ||
                (in_row_r == bb3_pkg::IN_ROW_W'(1) && in_col_r != '0);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // Read the column on a starting item and on the retry step; the retry
  // read is issued in S_RD, after the S_ADV write, so it sees the new contents.
  assign rd_en = (accept && (complete || in_tuser == bb3_pkg::CMD_PIXEL)) ||
                 (state_r == S_RD);
  assign wr_en = (state_r == S_ADV);

  // Neighbor validity from the output position.
  always_comb begin
    mask.row_ok[0] = out_row_r != '0;
    mask.row_ok[1] = bb3_pkg::IN_ROW_W'(out_row_r) < bb3_pkg::IN_ROW_W'(eff_h);
    mask.row_ok[2] = orow_inc < bb3_pkg::IN_ROW_W'(eff_h);
    mask.col_ok[0] = out_col_r != '0;
    mask.col_ok[1] = EW_W'(out_col_r) < eff_w;
    mask.col_ok[2] = ocol_inc < eff_w;
  end

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_upper (
    .clk(clk), .wr_en(wr_en), .wr_addr(in_col_r), .wr_data(mid_rd),
    .rd_en(rd_en), .rd_addr(in_col_r), .rd_data(up_rd)
  );

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_middle (
    .clk(clk), .wr_en(wr_en), .wr_addr(in_col_r), .wr_data(pix_r),
    .rd_en(rd_en), .rd_addr(in_col_r), .rd_data(mid_rd)
  );

  bb3_avg u_avg (
    .clk(clk), .start(state_r == S_SUM), .win(win_r), .mask(mask), .avg(avg)
  );

  always_comb begin
    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pix_nxt     = pix_r;
    cmpl_nxt    = cmpl_r;
    retry_nxt   = retry_r;
    last_nxt    = last_r;
    win_nxt     = win_r;
    ovld_nxt    = ovld_r && !out_tready;
    olast_nxt   = olast_r;
    odata_nxt   = odata_r;
    case (state_r)
      S_IDLE: begin
        // Start work on an accepted item; absorb a drain tick while the frame is still arriving.
        if (accept && (complete || in_tuser == bb3_pkg::CMD_PIXEL)) begin
          pix_nxt   = complete ? '0 : in_tdata;
          cmpl_nxt  = complete;
          retry_nxt = 1'b0;
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        // Shift the window, take the new column, advance the input position.
        for (int r = 0; r < 3; r++) begin
          win_nxt[r*3]   = win_r[r*3+1];
          win_nxt[r*3+1] = win_r[r*3+2];
        end
        win_nxt[2] = up_rd;
        win_nxt[5] = mid_rd;
        win_nxt[8] = pix_r;
        if (col_inc >= eff_w) begin
          in_col_nxt = '0;
          if (in_row_r != '1) begin
            in_row_nxt = in_row_r + 1'b1;
          end
        end else begin
          in_col_nxt = COL_W'(col_inc);
        end
        if (emit) begin
          state_nxt = S_SUM;
        end else if (cmpl_r && !retry_r) begin
          retry_nxt = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_ADV;
      end
      S_SUM: begin
        last_nxt = (orow_inc >= bb3_pkg::IN_ROW_W'(eff_h)) && (ocol_inc >= eff_w);
        if (last_nxt) begin
          // Frame done: rewind every position counter.
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_inc >= eff_w) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = COL_W'(ocol_inc);
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // Hold until the output register is free.
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = avg;
          olast_nxt = last_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fw_r      <= bb3_pkg::CFG_W'(640);
      fh_r      <= bb3_pkg::CFG_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cmpl_r    <= 1'b0;
      retry_r   <= 1'b0;
      last_r    <= 1'b0;
      win_r     <= '0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      cmpl_r    <= cmpl_nxt;
      retry_r   <= retry_nxt;
      last_r    <= last_nxt;
      win_r     <= win_nxt;
      ovld_r    <= ovld_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
          fw_r <= cfg_data;
        end else if (cfg_index == bb3_pkg::REG_FRAME_HEIGHT) begin
          fh_r <= cfg_data;
        end
      end
    end
    pix_r   <= pix_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = olast_r;
endmodule
`default_nettype wire

// ----- hw/rtl/bb3_checker.sv -----
// Port-level checks for the 3x3 box blur, bound to the top level.
// Depends on bb3_pkg and box_blur_3x3_edge_average_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_average_assert.svh"
module bb3_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);
  `BB3_AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "output dropped while stalled")
  `BB3_AST_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "output changed while stalled")
  `BB3_AST_NXT_ANY(a_rst_quiet, !rst_n, !out_tvalid, "output valid right after reset")
  `BB3_AST_NXT(a_pix_busy, in_tvalid && in_tready && in_tuser == bb3_pkg::CMD_PIXEL, !in_tready, "pixel transfer did not start work")
endmodule
bind box_blur_3x3_edge_average bb3_checker u_bb3_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire

// ----- tb/tb_box_blur_3x3_edge_average.sv -----
// Self-checking testbench for box_blur_3x3_edge_average: streams RGB frames,
// predicts every blurred pixel in a local model of the window and compares.
// Depends on bb3_pkg and the box_blur_3x3_edge_average RTL.
`timescale 1ns / 1ps
module tb_box_blur_3x3_edge_average;

  localparam int STORE_DEPTH = 2048;
  localparam int IDLE_LIMIT  = 5000;   // cycles with no transfer before giving up
  localparam int SETTLE      = 12;     // lets the block return to idle after the last result

  // Expected blurred pixel as it leaves the block.
  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } blur_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = bb3_pkg::REG_FRAME_WIDTH;
  logic [11:0] cfg_data = '0;

  box_blur_3x3_edge_average i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Window predictor: own copy of line stores, window and counters.
  // ---------------------------------------------------------------------------
  logic [11:0] width_reg = 12'd640;
  logic [11:0] height_reg = 12'd480;
  logic [23:0] row_above2 [STORE_DEPTH];
  logic [23:0] row_above1 [STORE_DEPTH];
  logic [23:0] win [9];
  int unsigned col_in, row_in, col_out, row_out;
  bit          frame_done;      // set when the frame's last pixel is predicted

  blur_px_t blur_expected[$];

  int items_sent, results_seen, mismatches, frames_run;
  int idle_in_pct, idle_out_pct;
  int stall_left;               // receiver hold-off, counted down by the receiver
  int quiet_cycles;

  function automatic int unsigned act_width();
    if (width_reg == 0) return 1;
    if (width_reg > STORE_DEPTH) return STORE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned act_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
  endfunction

  // Shift one pixel into the window; push an expected result if one leaves.
  function automatic bit shift_window(input logic [23:0] pix);
    int unsigned w, h, slot, cnt, q;
    logic [23:0] a2, a1;
    bit emit, last;
    bit rv[3], cv[3];
    int unsigned sum[3];
    blur_px_t px;
    w = act_width();
    h = act_height();
    slot = (col_in < STORE_DEPTH) ? col_in : 0;
    a2 = row_above2[slot];
    a1 = row_above1[slot];
    emit = row_in >= 2 || (row_in == 1 && col_in >= 1);
    row_above2[slot] = a1;
    row_above1[slot] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = a2;
    win[5] = a1;
    win[8] = pix;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < 32'hFFFFFF) row_in++;
    end
    if (!emit) return 1'b0;

    rv[0] = row_out >= 1; rv[1] = row_out < h; rv[2] = row_out + 1 < h;
    cv[0] = col_out >= 1; cv[1] = col_out < w; cv[2] = col_out + 1 < w;
    sum = '{0, 0, 0};
    cnt = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (rv[r] && cv[c]) begin
          for (int ch = 0; ch < 3; ch++) sum[ch] += win[r*3+c][ch*8 +: 8];
          cnt++;
        end
    // round half up: floor((2*sum + n) / (2*n))
    q = (cnt != 0) ? (2*sum[0] + cnt) / (2*cnt) : 0; px.red   = q[7:0];
    q = (cnt != 0) ? (2*sum[1] + cnt) / (2*cnt) : 0; px.green = q[7:0];
    q = (cnt != 0) ? (2*sum[2] + cnt) / (2*cnt) : 0; px.blue  = q[7:0];
    last = row_out + 1 >= h && col_out + 1 >= w;
    px.last = last;
    blur_expected.push_back(px);
    if (last) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
      frame_done = 1'b1;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // Apply one accepted transfer to the predictor.
  function automatic void predict_item(input logic cmd, input logic [23:0] pix);
    if (row_in < act_height()) begin
      // drain ticks are absorbed while the frame still needs pixels
      if (cmd != bb3_pkg::CMD_DRAIN) void'(shift_window(pix));
    end else begin
      // frame complete: any item releases output, data ignored
      if (!shift_window('0)) void'(shift_window('0));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 20)
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    blur_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_expected.size() == 0) begin
        report_mismatch("unexpected transfer, tdata", out_tdata, 0);
      end else begin
        want = blur_expected.pop_front();
        if (out_tdata[7:0]   !== want.red)   report_mismatch("red", out_tdata[7:0], want.red);
        if (out_tdata[15:8]  !== want.green)
          report_mismatch("green", out_tdata[15:8], want.green);
        if (out_tdata[23:16] !== want.blue)
          report_mismatch("blue", out_tdata[23:16], want.blue);
        if (out_tuser !== want.last)         report_mismatch("last", out_tuser, want.last);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one item; leaves tvalid high so back-to-back items have no gap.
  task automatic send_item(input logic cmd, input logic [23:0] pix);
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    predict_item(cmd, pix);
    items_sent++;
  endtask

  // Hold until every expected result has arrived and the pipeline is empty.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = val;
    else                                 height_reg = val;
  endtask

  task automatic set_size(input logic [11:0] w, input logic [11:0] h);
    write_reg(bb3_pkg::REG_FRAME_WIDTH, w);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // One full frame: pixels with some stray drains, then release until last.
  task automatic run_frame(input int noise_pct, input bit extreme_pix);
    int n;
    logic [23:0] pix;
    frame_done = 1'b0;
    n = act_width() * act_height();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(bb3_pkg::CMD_DRAIN, 24'($urandom));
      if (extreme_pix) pix = {$urandom_range(1) ? 8'hFF : 8'h00,
                              $urandom_range(1) ? 8'hFF : 8'h00,
                              $urandom_range(1) ? 8'hFF : 8'h00};
      else             pix = 24'($urandom);
      send_item(bb3_pkg::CMD_PIXEL, pix);
    end
    // pixels sent after completion must act as drain ticks
    while (!frame_done)
      send_item(($urandom_range(3) == 0) ? bb3_pkg::CMD_PIXEL : bb3_pkg::CMD_DRAIN,
                24'($urandom));
    frames_run++;
    in_tvalid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_small_frames();
    // interior, edges and corners on a 3x3 with saturated channels
    set_size(12'd3, 12'd3);
    run_frame(0, 1'b1);
    run_frame(30, 1'b0);
    // single row, single column, single pixel
    set_size(12'd4, 12'd1);
    run_frame(0, 1'b0);
    set_size(12'd1, 12'd3);
    run_frame(0, 1'b0);
    set_size(12'd1, 12'd1);
    run_frame(0, 1'b1);
  endtask

  task automatic test_size_extremes();
    // zero sizes act as one
    set_size(12'd0, 12'd2);
    run_frame(0, 1'b0);
    set_size(12'd3, 12'd0);
    run_frame(0, 1'b0);
    // tall frame, one column
    set_size(12'd1, 12'd300);
    run_frame(0, 1'b0);
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering: input must stall
    idle_in_pct = 0;
    idle_out_pct = 0;
    set_size(12'd6, 12'd5);
    stall_left = 400;
    run_frame(0, 1'b0);
  endtask

  task automatic test_random_frames(input int in_pct, input int out_pct, input int quota);
    int stop_at;
    idle_in_pct = in_pct;
    idle_out_pct = out_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0)
        set_size(12'($urandom_range(1, 40)), 12'($urandom_range(1, 4)));
      else
        set_size(12'($urandom_range(1, 9)), 12'($urandom_range(1, 7)));
      run_frame(($urandom_range(4) == 0) ? 20 : 0, $urandom_range(5) == 0);
    end
  endtask

  initial begin
    idle_in_pct = 0;
    idle_out_pct = 0;
    stall_left = 0;
    clear_window();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_frames();
    test_size_extremes();
    test_backpressure();
    test_random_frames(17, 66, 320);
    test_random_frames(66, 17, 320);
    test_random_frames(0, 0, 320);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("ran %0d frames, %0d input transfers, %0d blurred pixels checked",
             frames_run, items_sent, results_seen);
    $display("sizes from 1x1 up to 40 wide and 300 tall, with stray drains and stalls");
    if (mismatches == 0 && blur_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, blur_expected.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
